// ===== rtl/core/sra_pkg.sv =====
// sra_pkg: shared types and codes of the stack region allocator
`default_nettype none
package sra_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    // status codes of a result item
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD     = 2'd1;
    localparam logic [1:0] STATUS_NO_ROOM = 2'd2;
    localparam logic [1:0] STATUS_NOT_TOP = 2'd3;

    // fixed field widths
    localparam int TOP_W    = 17;
    localparam int OFFSET_W = 16;
    // header plus rounded size of a request that can still fit
    localparam int NEED_W   = 18;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classification made by the front
    typedef enum logic [2:0] {
        K_RESERVE,
        K_RELEASE,
        K_CLEAR,
        K_NULL,
        K_BAD
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic                  oversize;
        logic [NEED_W-1:0]     need;
        logic [OFFSET_W-1:0]   header;
    } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/sra_ram.sv =====
// sra_ram: generic single write port ram with registered read
`default_nettype none
module sra_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/sra_front.sv =====
// sra_front: accepts items, forms the exact product and classifies each item
`default_nettype none
module sra_front #(
    parameter int ALIGN_BYTES = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           command,
    input  wire logic [31:0]          num_elements,
    input  wire logic [31:0]          element_bytes,
    input  wire logic                 pointer_present,
    input  wire logic [15:0]          pointer_offset,
    input  wire logic                 q_full,
    output logic                      q_push,
    output sra_pkg::entry_t           q_entry
);
    import sra_pkg::*;

    localparam int ALIGN_LOG = $clog2(ALIGN_BYTES);

    logic                s1_valid_reg, s1_valid_next;
    kind_t               kind_reg, kind_next;
    logic [63:0]         product_reg;
    logic [OFFSET_W-1:0] header_reg;

    logic                in_accept;
    logic [TOP_W:0]      round_sum;
    logic [NEED_W-1:0]   rounded;

    assign in_ready  = !s1_valid_reg || !q_full;
    assign in_accept = in_valid && in_ready;
    assign q_push    = s1_valid_reg && !q_full;

    // classification that needs no allocator state
    always_comb
    begin
        kind_next = K_BAD;
        unique case (command)
            CMD_RESERVE:
            begin
                kind_next = (num_elements == 32'd0 || element_bytes == 32'd0)
                            ? K_BAD : K_RESERVE;
            end
            CMD_RELEASE:
            begin
                if (!pointer_present)
                begin
                    kind_next = K_NULL;
                end
                else if (pointer_offset < OFFSET_W'(ALIGN_BYTES)
                         || pointer_offset[ALIGN_LOG-1:0] != '0)
                begin
                    kind_next = K_BAD;
                end
                else
                begin
                    kind_next = K_RELEASE;
                end
            end
            CMD_CLEAR:
            begin
                kind_next = K_CLEAR;
            end
            default:
            begin
                kind_next = K_BAD;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg    <= kind_next;
            product_reg <= 64'(num_elements) * 64'(element_bytes);
            header_reg  <= pointer_offset - OFFSET_W'(ALIGN_BYTES);
        end
    end

    // round up to the alignment and add the header slot
    assign round_sum = {1'b0, product_reg[TOP_W-1:0]} + (TOP_W+1)'(ALIGN_BYTES - 1);
    assign rounded   = {round_sum[TOP_W:ALIGN_LOG], ALIGN_LOG'(0)};

    always_comb
    begin
        q_entry          = '0;
        q_entry.kind     = kind_reg;
        q_entry.oversize = |product_reg[63:TOP_W];
        q_entry.need     = rounded + NEED_W'(ALIGN_BYTES);
        q_entry.header   = header_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/core/sra_queue.sv =====
// sra_queue: short fifo of classified items between front and back
`default_nettype none
module sra_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire sra_pkg::entry_t  push_entry,
    input  wire logic             pop,
    output sra_pkg::entry_t       head_entry,
    output logic                  full,
    output logic                  empty
);
    import sra_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]      count_reg, count_next;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sra_back.sv =====
// sra_back: carries out reserve, release and clear against the block stack
`default_nettype none
module sra_back #(
    parameter int ALIGN_BYTES = 16,
    parameter int MAX_BLOCKS  = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire sra_pkg::entry_t               q_head,
    output logic                               q_pop,
    input  wire logic [16:0]                   region_limit,
    output logic                               ram_we,
    output logic [$clog2(MAX_BLOCKS)-1:0]      ram_waddr,
    output logic [16:0]                        ram_wdata,
    output logic [$clog2(MAX_BLOCKS)-1:0]      ram_raddr,
    input  wire logic [16:0]                   ram_rdata,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic [15:0]                        granted_offset,
    output logic [16:0]                        bytes_used
);
    import sra_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_BLOCKS);
    localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic {
        ST_DISPATCH,
        ST_LOOKUP
    } state_t;

    state_t              state_reg, state_next;
    logic [TOP_W-1:0]    top_reg, top_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [OFFSET_W-1:0] header_reg, header_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [OFFSET_W-1:0] granted_reg, granted_next;
    logic [TOP_W-1:0]    bytes_reg, bytes_next;

    logic                out_free;
    logic                emit;
    logic [TOP_W-1:0]    avail;
    logic                fits;
    logic [DEPTH_W-1:0]  depth_minus;

    assign out_free    = !out_valid_reg || out_ready;
    assign avail       = region_limit - top_reg;
    assign depth_minus = depth_reg - 1'b1;

    assign fits = (depth_reg < DEPTH_W'(MAX_BLOCKS))
                  && (top_reg <= region_limit)
                  && !q_head.oversize
                  && (q_head.need <= {1'b0, avail});

    assign ram_waddr = depth_reg[ADDR_W-1:0];
    assign ram_wdata = top_reg;
    assign ram_raddr = depth_minus[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        depth_next     = depth_reg;
        header_next    = header_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        granted_next   = granted_reg;
        bytes_next     = bytes_reg;
        emit           = 1'b0;
        q_pop          = 1'b0;
        ram_we         = 1'b0;

        unique case (state_reg)
            ST_DISPATCH:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop        = 1'b1;
                    granted_next = '0;
                    unique case (q_head.kind)
                        K_RESERVE:
                        begin
                            emit = 1'b1;
                            if (fits)
                            begin
                                ram_we       = 1'b1;
                                top_next     = top_reg + q_head.need[TOP_W-1:0];
                                depth_next   = depth_reg + 1'b1;
                                status_next  = STATUS_OK;
                                granted_next = top_reg[OFFSET_W-1:0] + OFFSET_W'(ALIGN_BYTES);
                            end
                            else
                            begin
                                status_next = STATUS_NO_ROOM;
                            end
                        end
                        K_RELEASE:
                        begin
                            if ({1'b0, q_head.header} >= top_reg)
                            begin
                                emit        = 1'b1;
                                status_next = STATUS_BAD;
                            end
                            else if (depth_reg == '0)
                            begin
                                emit        = 1'b1;
                                status_next = STATUS_NOT_TOP;
                            end
                            else
                            begin
                                // previous top is read this cycle, compared next
                                header_next = q_head.header;
                                state_next  = ST_LOOKUP;
                            end
                        end
                        K_CLEAR:
                        begin
                            emit        = 1'b1;
                            top_next    = '0;
                            depth_next  = '0;
                            status_next = STATUS_OK;
                        end
                        K_NULL:
                        begin
                            emit        = 1'b1;
                            status_next = STATUS_OK;
                        end
                        default:
                        begin
                            emit        = 1'b1;
                            status_next = STATUS_BAD;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                emit         = 1'b1;
                granted_next = '0;
                state_next   = ST_DISPATCH;
                if (ram_rdata == {1'b0, header_reg})
                begin
                    top_next    = {1'b0, header_reg};
                    depth_next  = depth_minus;
                    status_next = STATUS_OK;
                end
                else
                begin
                    status_next = STATUS_NOT_TOP;
                end
            end
            default:
            begin
                state_next = ST_DISPATCH;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            bytes_next     = top_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DISPATCH;
            top_reg       <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        header_reg  <= header_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        bytes_reg   <= bytes_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_offset = granted_reg;
    assign bytes_used     = bytes_reg;

endmodule
`default_nettype wire

// ===== rtl/core/stack_region_allocator.sv =====
// stack_region_allocator: top level of the lifo region allocator
//
// lifo bump allocator over a region of region_size bytes (clamped to
// 2^REGION_BITS). a reserve asks for num_elements * element_bytes bytes, rounded
// up to ALIGN_BYTES, plus one ALIGN_BYTES header slot; on success it returns the
// payload offset (old top plus ALIGN_BYTES). a release frees only the topmost
// block, a clear empties the region. every item gives exactly one result item
// carrying status, granted offset and the bytes in use afterwards. the front
// registers the exact 64-bit product (one 32x32 multiplier) and then
// classifies the item into a two-entry queue; the back executes from the
// queue. reserve, clear, null release and rejected items finish in the dispatch
// state, so one item per cycle can be sustained while results are taken; a
// release that reaches the stack lookup also passes the lookup state, which waits
// on the registered read of the previous-top ram (MAX_BLOCKS x 17 bits). an item
// passes the front register, the queue and the result register. region_size
// is written through cfg_write_en/cfg_write_data and should only change while
// no item is in flight. the previous-top ram needs no clearing after reset.
`default_nettype none
module stack_region_allocator #(
    parameter int REGION_BITS = 16,
    parameter int ALIGN_BYTES = 16,
    parameter int MAX_BLOCKS  = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_write_en,
    input  wire logic [16:0] cfg_write_data,
    // input item channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] num_elements,
    input  wire logic [31:0] element_bytes,
    input  wire logic        pointer_present,
    input  wire logic [15:0] pointer_offset,
    // result item channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      granted_offset,
    output logic [16:0]      bytes_used
);
    import sra_pkg::*;

    localparam int ADDR_W = $clog2(MAX_BLOCKS);

    // region cap; at 17 bits or more the register itself is the bound
    localparam logic [TOP_W-1:0] REGION_CAP =
        (REGION_BITS >= TOP_W) ? {TOP_W{1'b1}} : TOP_W'(1 << REGION_BITS);

    logic [TOP_W-1:0] region_size_reg;
    logic [TOP_W-1:0] region_limit;

    // queue hookup
    entry_t           push_entry;
    entry_t           head_entry;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;

    // previous-top stack ram
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [TOP_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [TOP_W-1:0]  ram_rdata;

    // region size register, written without handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_size_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            region_size_reg <= cfg_write_data;
        end
    end

    assign region_limit = (region_size_reg > REGION_CAP) ? REGION_CAP : region_size_reg;

    // front: accept, multiply, classify
    sra_front #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .num_elements    (num_elements),
        .element_bytes   (element_bytes),
        .pointer_present (pointer_present),
        .pointer_offset  (pointer_offset),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (push_entry)
    );

    // decoupling queue
    sra_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    // back: stack top, block depth and the result register
    sra_back #(
        .ALIGN_BYTES (ALIGN_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (head_entry),
        .q_pop          (q_pop),
        .region_limit   (region_limit),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_offset (granted_offset),
        .bytes_used     (bytes_used)
    );

    // one entry per live block: the top before that block was granted
    sra_ram #(
        .WIDTH (TOP_W),
        .DEPTH (MAX_BLOCKS)
    ) u_prev_tops (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ===== bench/stack_region_allocator_test.sv =====
// stack_region_allocator_test: self-checking bench for the lifo region allocator
`default_nettype none
module stack_region_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sra_pkg::*;

    // block build, kept at the defaults of the top level
    localparam int REGION_BITS = 16;
    localparam int ALIGN_BYTES = 16;
    localparam int MAX_BLOCKS  = 4096;

    // the one command code that the package leaves unnamed
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam int CLK_PERIOD     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    // idle wait before a region write and at the end of the run, with margin
    localparam int TAIL_CYCLES    = 12;
    localparam int PHASE_ITEMS    = 206;
    localparam int NUM_PHASES     = 8;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFFSET_W-1:0] granted;
        logic [TOP_W-1:0]    used;
    } alloc_reply_t;

    // tracks the allocator state item by item and holds the replies still owed
    class region_tracker;
        logic [TOP_W-1:0] region_size;
        logic [TOP_W-1:0] stack_top;
        int unsigned      block_depth;
        logic [TOP_W-1:0] previous_tops [MAX_BLOCKS];
        alloc_reply_t     owed_replies [$];
        int unsigned      errors;

        function new();
            region_size = '0;
            stack_top   = '0;
            block_depth = 0;
            errors      = 0;
        endfunction

        function int unsigned pending();
            return owed_replies.size();
        endfunction

        // clamp of the configured size to the addressable region
        function logic [63:0] usable_limit();
            logic [63:0] cap;
            cap = 64'd1 << REGION_BITS;
            return (64'(region_size) < cap) ? 64'(region_size) : cap;
        endfunction

        function void note_item(input logic [1:0] cmd, input logic [31:0] count,
                                input logic [31:0] size, input logic present,
                                input logic [15:0] offset);
            logic [63:0]  product;
            logic [63:0]  rounded;
            logic [63:0]  limit;
            logic [63:0]  room;
            logic [63:0]  header;
            alloc_reply_t reply;
            reply.status  = STATUS_OK;
            reply.granted = '0;
            case (cmd)
                CMD_RESERVE:
                begin
                    if (count == 0 || size == 0)
                        reply.status = STATUS_BAD;
                    else
                    begin
                        // exact product, rounded up to the slot size
                        product = 64'(count) * 64'(size);
                        rounded = (product + 64'(ALIGN_BYTES - 1)) / 64'(ALIGN_BYTES)
                                  * 64'(ALIGN_BYTES);
                        limit   = usable_limit();
                        if (block_depth >= MAX_BLOCKS || 64'(stack_top) > limit)
                            reply.status = STATUS_NO_ROOM;
                        else
                        begin
                            room = limit - 64'(stack_top);
                            if (rounded > room || 64'(ALIGN_BYTES) > room - rounded)
                                reply.status = STATUS_NO_ROOM;
                            else
                            begin
                                reply.granted = OFFSET_W'(64'(stack_top) + ALIGN_BYTES);
                                previous_tops[block_depth] = stack_top;
                                block_depth++;
                                stack_top = TOP_W'(64'(stack_top) + ALIGN_BYTES + rounded);
                            end
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    if (present)
                    begin
                        if (offset < ALIGN_BYTES)
                            reply.status = STATUS_BAD;
                        else
                        begin
                            header = 64'(offset) - ALIGN_BYTES;
                            if (header >= 64'(stack_top) || header % ALIGN_BYTES != 0)
                                reply.status = STATUS_BAD;
                            else if (block_depth == 0)
                                reply.status = STATUS_NOT_TOP;
                            else if (64'(previous_tops[block_depth-1]) != header)
                                reply.status = STATUS_NOT_TOP;
                            else
                            begin
                                block_depth--;
                                stack_top = TOP_W'(header);
                            end
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    stack_top   = '0;
                    block_depth = 0;
                end
                default:
                    reply.status = STATUS_BAD;
            endcase
            reply.used = stack_top;
            owed_replies.push_back(reply);
        endfunction

        function void check_reply(input logic [1:0] got_status,
                                  input logic [OFFSET_W-1:0] got_granted,
                                  input logic [TOP_W-1:0] got_used);
            alloc_reply_t want;
            if (owed_replies.size() == 0)
            begin
                $display("%0t: reply with no item waiting: status %0d granted %0d used %0d",
                         $time, got_status, got_granted, got_used);
                errors++;
                return;
            end
            want = owed_replies.pop_front();
            if (got_status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
                errors++;
            end
            if (got_granted !== want.granted)
            begin
                $display("%0t: granted_offset expected %0d actual %0d",
                         $time, want.granted, got_granted);
                errors++;
            end
            if (got_used !== want.used)
            begin
                $display("%0t: bytes_used expected %0d actual %0d",
                         $time, want.used, got_used);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [16:0] cfg_write_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [31:0] num_elements;
    logic [31:0] element_bytes;
    logic        pointer_present;
    logic [15:0] pointer_offset;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [15:0] granted_offset;
    logic [16:0] bytes_used;

    region_tracker tracker = new();

    // sender burst bookkeeping
    int unsigned burst_left;

    // receiver stall pattern state
    int unsigned rx_mode       = 0;
    int unsigned rx_phase_left = 0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_tick       = 0;

    int unsigned idle_cycles = 0;

    stack_region_allocator #(
        .REGION_BITS (REGION_BITS),
        .ALIGN_BYTES (ALIGN_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .num_elements    (num_elements),
        .element_bytes   (element_bytes),
        .pointer_present (pointer_present),
        .pointer_offset  (pointer_offset),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_offset  (granted_offset),
        .bytes_used      (bytes_used)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // receiver: picks a new stall style at random whenever its phase runs out
    //   0 always ready, 1 coin flip, 2 fixed duty pattern, 3 occasional long stalls
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_phase_left == 0)
        begin
            rx_mode       <= $urandom_range(0, 3);
            rx_phase_left <= $urandom_range(20, 200);
        end
        else
            rx_phase_left <= rx_phase_left - 1;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (rx_tick % 8) < 5;
            default:
            begin
                if (rx_stall_left != 0)
                begin
                    out_ready     <= 1'b0;
                    rx_stall_left <= rx_stall_left - 1;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    out_ready     <= 1'b0;
                    rx_stall_left <= $urandom_range(1, 20);
                end
                else
                    out_ready <= 1'b1;
            end
        endcase
    end

    // all handshake signals are steady at the falling edge, so sample there:
    // a pair seen here completes at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_reply(status, granted_offset, bytes_used);
    end

    // watchdog on cycles with no item moving on either channel
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("stack_region_allocator_test: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // offers one item; starts a new burst after a random gap when the old one is used up
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] count,
                             input logic [31:0] size, input logic present,
                             input logic [15:0] offset);
        int unsigned gap;
        bit          took;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid        <= 1'b1;
        command         <= cmd;
        num_elements    <= count;
        element_bytes   <= size;
        pointer_present <= present;
        pointer_offset  <= offset;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        tracker.note_item(cmd, count, size, present, offset);
        burst_left--;
    endtask

    // holds the sender off until every owed reply has come back
    task automatic wait_replies();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // region size only changes with nothing in flight
    task automatic write_region(input logic [16:0] value);
        wait_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        tracker.region_size = value;
    endtask

    initial
    begin
        logic [16:0] region_plan [NUM_PHASES];
        int unsigned pick;
        int unsigned depth_now;
        logic [63:0] room_now;
        logic [1:0]  cmd;
        logic [31:0] cnt;
        logic [31:0] sz;
        logic        pres;
        logic [15:0] off;

        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_write_data  = '0;
        in_valid        = 1'b0;
        command         = CMD_RESERVE;
        num_elements    = '0;
        element_bytes   = '0;
        pointer_present = 1'b0;
        pointer_offset  = '0;
        burst_left      = 0;

        // large, clamped, tiny (below what is in use), empty and odd sizes
        region_plan = '{17'd65536, 17'd131071, 17'd48, 17'd4096,
                        17'd0, 17'd1000, 17'd65535, 17'd512};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // region still at its reset size of zero: nothing fits
        send_item(CMD_RESERVE, 32'd1, 32'd1, 1'b0, 16'd0);

        write_region(17'd256);
        // zero count and zero size
        send_item(CMD_RESERVE, 32'd0, 32'd5, 1'b1, 16'hffff);
        send_item(CMD_RESERVE, 32'd5, 32'd0, 1'b0, 16'h0000);
        // largest exact product
        send_item(CMD_RESERVE, 32'hffffffff, 32'hffffffff, 1'b1, 16'hffff);
        // two small blocks, the second rounded up to one slot
        send_item(CMD_RESERVE, 32'd1, 32'd1, 1'b0, 16'd0);
        send_item(CMD_RESERVE, 32'd3, 32'd5, 1'b0, 16'd0);
        // null release
        send_item(CMD_RELEASE, $urandom, $urandom, 1'b0, 16'hffff);
        // pointer below one slot, misaligned header, header past the top
        send_item(CMD_RELEASE, $urandom, $urandom, 1'b1, 16'd8);
        send_item(CMD_RELEASE, $urandom, $urandom, 1'b1, 16'd24);
        send_item(CMD_RELEASE, $urandom, $urandom, 1'b1, 16'd80);
        // live block that is not the topmost one, then the topmost one
        send_item(CMD_RELEASE, $urandom, $urandom, 1'b1, 16'd16);
        send_item(CMD_RELEASE, $urandom, $urandom, 1'b1, 16'd48);
        // unknown command with every field high
        send_item(CMD_UNKNOWN, 32'hffffffff, 32'hffffffff, 1'b1, 16'hffff);
        // request that fills the region to the last byte, then one more
        send_item(CMD_RESERVE, 32'd13, 32'd16, 1'b0, 16'd0);
        send_item(CMD_RESERVE, 32'd1, 32'd1, 1'b0, 16'd0);
        send_item(CMD_CLEAR, $urandom, $urandom, 1'b1, 16'hffff);
        // exact fit from empty, and one byte too many after a clear
        send_item(CMD_RESERVE, 32'd1, 32'd240, 1'b0, 16'd0);
        send_item(CMD_CLEAR, 32'd0, 32'd0, 1'b0, 16'd0);
        send_item(CMD_RESERVE, 32'd1, 32'd241, 1'b0, 16'd0);
        send_item(CMD_RESERVE, 32'h80000000, 32'd2, 1'b0, 16'd0);

        // random phases; state carries over, so a shrunken region can sit below the top.
        // a full block stack cannot be reached: even the smallest block takes two slots
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_region(region_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick      = $urandom_range(0, 99);
                depth_now = tracker.block_depth;
                cmd       = CMD_RESERVE;
                cnt       = $urandom;
                sz        = $urandom;
                pres      = 1'($urandom_range(0, 1));
                off       = 16'($urandom_range(0, 65535));
                if (pick < 40)
                begin
                    // ordinary small request
                    cnt = $urandom_range(1, 8);
                    sz  = $urandom_range(1, 64);
                end
                else if (pick < 44)
                begin
                    // request around the space left, to fill the region up
                    if (64'(tracker.stack_top) < tracker.usable_limit())
                        room_now = tracker.usable_limit() - 64'(tracker.stack_top);
                    else
                        room_now = 0;
                    cnt = 32'd1;
                    if (room_now > 24)
                        sz = 32'(room_now - 24 + $urandom_range(0, 16));
                    else
                        sz = $urandom_range(1, 32);
                end
                else if (pick < 72)
                begin
                    // release of the topmost block
                    cmd  = CMD_RELEASE;
                    pres = 1'b1;
                    if (depth_now > 0)
                        off = 16'(tracker.previous_tops[depth_now-1] + ALIGN_BYTES);
                end
                else if (pick < 78)
                begin
                    // release of a live block further down
                    cmd  = CMD_RELEASE;
                    pres = 1'b1;
                    if (depth_now > 1)
                        off = 16'(tracker.previous_tops[$urandom_range(0, depth_now-2)]
                                  + ALIGN_BYTES);
                end
                else if (pick < 86)
                begin
                    // stray pointer, aligned half of the time
                    cmd = CMD_RELEASE;
                    if ($urandom_range(0, 1) == 1)
                        off = off & 16'hfff0;
                end
                else if (pick < 91)
                begin
                    // wide random request, mostly too big
                    if ($urandom_range(0, 3) == 0)
                        cnt = $urandom_range(1, 4);
                end
                else if (pick < 94)
                    cmd = CMD_CLEAR;
                else if (pick < 97)
                    cmd = CMD_UNKNOWN;
                else if ($urandom_range(0, 1) == 1)
                    cnt = '0;
                else
                    sz = '0;
                send_item(cmd, cnt, sz, pres, off);
                // now and then let everything drain mid-phase
                if ($urandom_range(0, 199) == 0)
                    wait_replies();
            end
        end

        wait_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("stack_region_allocator_test: done, clean");
        else
            $display("stack_region_allocator_test: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
